// File: hw/rtl/eida_pkg.sv
// shared operation codes, status codes and stream field layout for the id allocator
package eida_pkg;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_SET     = 2'd2;
    localparam logic [1:0] OP_GET     = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam int ID_IN_W    = 16;
    localparam int SIG_IO_W   = 32;
    localparam int NEW_ID_W   = 8;
    localparam int LIVE_OUT_W = 9;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

endpackage

// File: hw/rtl/eida_ram.sv
// single-port-write, single-port-read synchronous memory with registered read data
module eida_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/entity_id_allocator_with_signatures.sv
// top level of the id allocator: free-id queue, live count and per-id signature store
//
// usage:
//   s_ channel carries one command item: s_tuser holds the operation (create,
//   destroy, set signature, get signature), s_tdata the id and the signature.
//   m_ channel returns exactly one result item per command, in order.
//   the result of an accepted item is registered and is on m_ in the cycle
//   after the accept; one item per cycle is sustained while m_tready
//   stays high; the single output register is the limit.
//   the free-id queue and the signature store are synchronous memories read
//   at accept time; every write is known at accept time, so no forwarding.
//   after reset a clearing pass writes id i into queue slot i and zero into
//   every signature; s_tready stays low during it.
//   when m_tready is low the held result stays on m_ and s_tready drops
//   until the result is taken.
//   errors (no free id, id out of range, destroy with none live) are reported
//   in the result status and leave the state unchanged.
module entity_id_allocator_with_signatures
    import eida_pkg::*;
#(
    parameter int MAX_IDS        = 256,
    parameter int SIGNATURE_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // entity_id[15:0], signature_in[47:16]
    input  logic [1:0]           s_tuser,   // op[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // new_id[7:0], signature_out[39:8],
                                            // live_count[48:40], zero fill
    output logic [1:0]           m_tuser    // status[1:0]
);

    localparam int ID_W  = $clog2(MAX_IDS);
    localparam int CNT_W = $clog2(MAX_IDS + 1);
    localparam logic [ID_W-1:0]  IDX_LAST = ID_W'(MAX_IDS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_IDS);

    logic [ID_W-1:0]  head_reg, head_next;
    logic [ID_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             clr_busy_reg, clr_busy_next;
    logic [ID_W-1:0]  clr_addr_reg, clr_addr_next;
    logic             m_valid_reg, m_valid_next;
    logic             res_create_reg, res_create_next;
    logic             res_get_reg, res_get_next;
    status_t          res_status_reg, res_status_next;
    logic [CNT_W-1:0] res_count_reg, res_count_next;

    op_t                     in_op;
    logic [ID_IN_W-1:0]      in_id;
    logic [SIG_IO_W-1:0]     in_sig;
    logic                    s_accept;
    logic                    in_range;
    logic [ID_W-1:0]         id_idx;
    logic                    is_full;
    logic                    is_none;
    logic                    do_create, do_destroy, do_set, do_get;
    status_t                 status_now;
    logic [SIGNATURE_BITS+SIG_IO_W-1:0] sig_wide;
    logic [SIGNATURE_BITS-1:0] sig_masked;

    logic                      q_we, q_re;
    logic [ID_W-1:0]           q_waddr, q_wdata, q_rdata;
    logic                      g_we, g_re;
    logic [ID_W-1:0]           g_waddr;
    logic [SIGNATURE_BITS-1:0] g_wdata, g_rdata;

    logic [ID_W+NEW_ID_W-1:0]         new_id_wide;
    logic [SIGNATURE_BITS+SIG_IO_W-1:0] sig_out_wide;
    logic [CNT_W+LIVE_OUT_W-1:0]      live_wide;
    logic [NEW_ID_W-1:0]              out_new_id;
    logic [SIG_IO_W-1:0]              out_sig;
    logic [LIVE_OUT_W-1:0]            out_live;

    assign in_op  = s_tuser;
    assign in_id  = s_tdata[15:0];
    assign in_sig = s_tdata[47:16];

    assign s_tready = !clr_busy_reg && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign in_range = {1'b0, in_id} < (ID_IN_W + 1)'(MAX_IDS);
    assign id_idx   = in_id[ID_W-1:0];
    assign is_full  = count_reg == CNT_FULL;
    assign is_none  = count_reg == '0;

    assign sig_wide   = {{SIGNATURE_BITS{1'b0}}, in_sig};
    assign sig_masked = sig_wide[SIGNATURE_BITS-1:0];

    always_comb begin
        do_create  = 1'b0;
        do_destroy = 1'b0;
        do_set     = 1'b0;
        do_get     = 1'b0;
        status_now = ST_OK;
        unique case (in_op)
            OP_CREATE: begin
                if (is_full) begin
                    status_now = ST_FULL;
                end else begin
                    do_create = 1'b1;
                end
            end
            OP_DESTROY: begin
                if (!in_range) begin
                    status_now = ST_RANGE;
                end else if (is_none) begin
                    status_now = ST_EMPTY;
                end else begin
                    do_destroy = 1'b1;
                end
            end
            OP_SET: begin
                if (!in_range) begin
                    status_now = ST_RANGE;
                end else begin
                    do_set = 1'b1;
                end
            end
            OP_GET: begin
                if (!in_range) begin
                    status_now = ST_RANGE;
                end else begin
                    do_get = 1'b1;
                end
            end
            default: begin
                status_now = ST_OK;
            end
        endcase
    end

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        res_create_next = res_create_reg;
        res_get_next    = res_get_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        if (s_accept) begin
            if (do_create) begin
                head_next  = (head_reg == IDX_LAST) ? '0 : head_reg + ID_W'(1);
                count_next = count_reg + CNT_W'(1);
            end
            if (do_destroy) begin
                tail_next  = (tail_reg == IDX_LAST) ? '0 : tail_reg + ID_W'(1);
                count_next = count_reg - CNT_W'(1);
            end
            res_create_next = do_create;
            res_get_next    = do_get;
            res_status_next = status_now;
            res_count_next  = count_next;
        end
    end

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + ID_W'(1);
            if (clr_addr_reg == IDX_LAST) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_create_reg <= res_create_next;
        res_get_reg    <= res_get_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
    end

    // free-id queue
    assign q_we    = clr_busy_reg || (s_accept && do_destroy);
    assign q_waddr = clr_busy_reg ? clr_addr_reg : tail_reg;
    assign q_wdata = clr_busy_reg ? clr_addr_reg : id_idx;
    assign q_re    = s_accept && do_create;

    eida_ram #(
        .DEPTH (MAX_IDS),
        .WIDTH (ID_W)
    ) u_free_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    // signature store
    assign g_we    = clr_busy_reg || (s_accept && (do_destroy || do_set));
    assign g_waddr = clr_busy_reg ? clr_addr_reg : id_idx;
    assign g_wdata = (clr_busy_reg || do_destroy) ? '0 : sig_masked;
    assign g_re    = s_accept && do_get;

    eida_ram #(
        .DEPTH (MAX_IDS),
        .WIDTH (SIGNATURE_BITS)
    ) u_sig_store (
        .aclk  (aclk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (id_idx),
        .rdata (g_rdata)
    );

    assign new_id_wide  = {{NEW_ID_W{1'b0}}, q_rdata};
    assign sig_out_wide = {{SIG_IO_W{1'b0}}, g_rdata};
    assign live_wide    = {{LIVE_OUT_W{1'b0}}, res_count_reg};

    assign out_new_id = res_create_reg ? new_id_wide[NEW_ID_W-1:0] : '0;
    assign out_sig    = res_get_reg ? sig_out_wide[SIG_IO_W-1:0] : '0;
    assign out_live   = live_wide[LIVE_OUT_W-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_status_reg;
    assign m_tdata  = {7'b0, out_live, out_sig, out_new_id};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("live count above id capacity");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_tready)
        else $error("item accepted during clearing pass");

    a_create_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && do_create) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("create did not raise live count");

    a_destroy_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && do_destroy) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("destroy did not lower live count");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tvalid && m_tuser == $past(status_now)))
        else $error("result missing after accepted item");
`endif

endmodule
